// ===== design/lws_pkg.sv =====
// Shared types and constants for the latency window stabilizer.
`default_nettype none

package lws_pkg;

  localparam int unsigned PHASE_W   = 4;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DEV_W     = 16;
  localparam int unsigned STABLE_W  = 18;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned SQ_W      = 32;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RMW,
    S_DSTART,
    S_DWAIT,
    S_CHK,
    S_WALK,
    S_QSTART,
    S_QWAIT,
    S_FIN,
    S_EMIT
  } lws_state_e;

endpackage

`default_nettype wire

// ===== design/lws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lws_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/lws_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module lws_div #(
  parameter int unsigned NUM_W = 21,
  parameter int unsigned DEN_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

// ===== design/lws_sqrt.sv =====
// Ceiling of sqrt(ssq / cnt): smallest d with d*d*cnt >= ssq, one root bit at a time (square, multiply, compare).
`default_nettype none

module lws_sqrt
  import lws_pkg::*;
#(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned SSQ_W = 37
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SSQ_W-1:0] ssq_i,
  input  wire logic [CNT_W-1:0] cnt_i,
  output logic                  done_o,
  output logic      [DEV_W-1:0] dev_o
);

  localparam int unsigned BIT_W = $clog2(DEV_W);

  logic             busy_q;
  logic             done_q;
  logic [1:0]       sub_q;
  logic [BIT_W-1:0] bit_q;
  logic [DEV_W-1:0] root_q;
  logic [SQ_W-1:0]  sq_q;
  logic [SSQ_W-1:0] prod_q;
  logic [DEV_W-1:0] cand;

  assign cand = root_q | (DEV_W'(1) << bit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sub_q  <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        sub_q  <= '0;
        bit_q  <= BIT_W'(DEV_W - 1);
      end else if (busy_q) begin
        if (sub_q == 2'd2) begin
          sub_q <= '0;
          bit_q <= bit_q - 1'b1;
          if (bit_q == '0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end else begin
          sub_q <= sub_q + 1'b1;
        end
      end
    end
  end

  // greedy search for the largest root with root*root*cnt < ssq
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      root_q <= '0;
    end else if (busy_q) begin
      case (sub_q)
        2'd0:    sq_q   <= cand * cand;
        2'd1:    prod_q <= SSQ_W'(sq_q) * SSQ_W'(cnt_i);
        default: if (prod_q < ssq_i) root_q <= cand;
      endcase
    end
  end

  assign done_o = done_q;
  assign dev_o  = (ssq_i == '0) ? '0 :
                  (&root_q)     ? root_q : root_q + 1'b1;

endmodule

`default_nettype wire

// ===== design/latency_window_stabilizer.sv =====
// Top level: sample ring, running count and sum, mean/deviation sequencer, output register.
//
// Usage: one item on the s_axis channel per tick. tdata carries the tick phase and
// the latest latency; only a tick with phase zero pushes the latency into the
// ring window (a zero latency empties that slot). One result item per input item
// leaves on m_axis: tuser carries the sampled and updated flags, tdata the count
// of filled slots and the held mean, deviation and stable latency.
// Throughput: one item at a time; the next item is taken in the cycle after the result
// is loaded. A tick with nonzero phase goes straight to the output register. A sampled
// tick runs the ring read-modify-write and, unless the window is then empty, the divider;
// when the mean is recomputed it also runs the deviation pass and the root search:
// the divider gives one bit a cycle, the deviation pass reads one ring entry a
// cycle through the RAM port, and the root search squares, multiplies and compares
// for each bit on its multiplier.
// Reset empties the window through one valid bit per slot and clears all held
// values; no clearing pass. A stalled receiver holds the result in the output
// register; the block still takes and works on one more item, then holds its
// result and takes no further item until the output register frees up.
`default_nettype none

module latency_window_stabilizer
  import lws_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [3:0] tick_phase, [19:4] latency_sample_ms
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [4:0] valid_count, [20:5] mean_ms, [36:21] std_dev_ms, [54:37] stable_ms
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] sampled, [1] updated
  output logic      [OUT_USER_W-1:0] m_axis_tuser
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;
  localparam int unsigned SSQ_W  = SQ_W + CNT_W;
  localparam int unsigned WALK_W = $clog2(WINDOW_DEPTH + 3);

  lws_state_e state_q, state_d;

  logic [SLOT_W-1:0]       slot_q;
  logic [WINDOW_DEPTH-1:0] vld_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [SUM_W-1:0]        sum_q;
  logic [SAMPLE_W-1:0]     sample_q;
  logic                    sampled_q;
  logic                    updated_q;
  logic [SAMPLE_W-1:0]     held_mean_q;
  logic [DEV_W-1:0]        held_dev_q;
  logic [STABLE_W-1:0]     held_stable_q;
  logic [WALK_W-1:0]       walk_q;
  logic                    vld_rd_q;
  logic                    rd_pend_q;
  logic signed [SAMPLE_W:0] diff_q;
  logic [SQ_W-1:0]         sq_q;
  logic [SSQ_W-1:0]        ssq_q;
  logic                    out_vld_q;
  logic [OUT_DATA_W-1:0]   out_data_q;
  logic [OUT_USER_W-1:0]   out_user_q;

  // control from the sequencer
  logic              accept;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic              ram_we;
  logic              div_start;
  logic              sqrt_start;
  logic              walk_rd;
  logic              emit_load;

  logic [SAMPLE_W-1:0]      ram_rdata;
  logic                     div_done;
  logic [SUM_W-1:0]         quot;
  logic                     sqrt_done;
  logic [DEV_W-1:0]         dev;
  logic [SAMPLE_W-1:0]      old_val;
  logic [SAMPLE_W-1:0]      mean_new;
  logic signed [SAMPLE_W:0] mdiff;
  logic [SAMPLE_W-1:0]      adiff;
  logic                     take_mean;
  logic signed [2*SAMPLE_W+1:0] sq_full;
  logic [COUNT_W-1:0]       count_sat;

  lws_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(sample_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  lws_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (sum_q + SUM_W'(cnt_q) - SUM_W'(1)),
    .den_i  (cnt_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  lws_sqrt #(
    .CNT_W(CNT_W),
    .SSQ_W(SSQ_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .ssq_i  (ssq_q),
    .cnt_i  (cnt_q),
    .done_o (sqrt_done),
    .dev_o  (dev)
  );

  assign old_val   = vld_rd_q ? ram_rdata : '0;
  assign mean_new  = quot[SAMPLE_W-1:0];
  assign mdiff     = $signed({1'b0, mean_new}) - $signed({1'b0, held_mean_q});
  assign adiff     = mdiff[SAMPLE_W] ? SAMPLE_W'(-mdiff) : mdiff[SAMPLE_W-1:0];
  assign take_mean = (adiff > held_dev_q) || (cnt_q < CNT_W'(WINDOW_DEPTH));
  assign sq_full   = diff_q * diff_q;
  assign count_sat = (cnt_q > CNT_W'(2**COUNT_W - 1)) ? '1 : COUNT_W'(cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (s_axis_tvalid) begin
                  state_d = (s_axis_tdata[PHASE_W-1:0] == '0) ? S_RMW : S_EMIT;
                end
      S_RMW:    state_d = S_DSTART;
      S_DSTART: state_d = (cnt_q == '0) ? S_EMIT : S_DWAIT;
      S_DWAIT:  if (div_done) state_d = S_CHK;
      S_CHK:    state_d = take_mean ? S_WALK : S_EMIT;
      S_WALK:   if (walk_q == WALK_W'(WINDOW_DEPTH + 2)) state_d = S_QSTART;
      S_QSTART: state_d = S_QWAIT;
      S_QWAIT:  if (sqrt_done) state_d = S_FIN;
      S_FIN:    state_d = S_EMIT;
      S_EMIT:   if (!out_vld_q || m_axis_tready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    walk_rd       = 1'b0;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    sqrt_start    = 1'b0;
    emit_load     = 1'b0;
    ram_raddr     = slot_q;
    unique case (state_q)
      S_IDLE:   s_axis_tready = 1'b1;
      S_RMW:    ram_we = 1'b1;
      S_DSTART: div_start = (cnt_q != '0);
      S_WALK:   begin
                  walk_rd   = (walk_q < WALK_W'(WINDOW_DEPTH));
                  ram_raddr = walk_q[SLOT_W-1:0];
                end
      S_QSTART: sqrt_start = 1'b1;
      S_EMIT:   emit_load = !out_vld_q || m_axis_tready;
      default:  ;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign ram_re = accept || walk_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      slot_q        <= '0;
      vld_q         <= '0;
      cnt_q         <= '0;
      sum_q         <= '0;
      held_mean_q   <= '0;
      held_dev_q    <= '0;
      held_stable_q <= '0;
      sampled_q     <= 1'b0;
      updated_q     <= 1'b0;
      walk_q        <= '0;
      rd_pend_q     <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= walk_rd;
      if (accept) begin
        sampled_q <= (s_axis_tdata[PHASE_W-1:0] == '0);
        updated_q <= 1'b0;
      end
      // replace the oldest slot, keeping count and sum in step
      if (ram_we) begin
        vld_q[slot_q] <= 1'b1;
        cnt_q <= cnt_q + CNT_W'(sample_q != '0) - CNT_W'(old_val != '0);
        sum_q <= sum_q + SUM_W'(sample_q) - SUM_W'(old_val);
        slot_q <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      end
      if (state_q == S_CHK) begin
        walk_q <= '0;
        if (take_mean) held_mean_q <= mean_new;
      end else if (state_q == S_WALK) begin
        walk_q <= walk_q + 1'b1;
      end
      if (state_q == S_FIN) begin
        held_dev_q    <= dev;
        held_stable_q <= STABLE_W'(held_mean_q) + STABLE_W'({dev, 1'b0});
        updated_q     <= 1'b1;
      end
      if (emit_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload and deviation pipeline: read, difference, square, accumulate
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= s_axis_tdata[PHASE_W +: SAMPLE_W];
    end
    if (ram_re) begin
      vld_rd_q <= vld_q[ram_raddr];
    end
    diff_q <= (rd_pend_q && vld_rd_q && (ram_rdata != '0)) ?
              $signed({1'b0, ram_rdata}) - $signed({1'b0, held_mean_q}) : '0;
    sq_q   <= sq_full[SQ_W-1:0];
    if (state_q == S_CHK) begin
      ssq_q <= '0;
    end else if (state_q == S_WALK) begin
      ssq_q <= ssq_q + SSQ_W'(sq_q);
    end
    if (emit_load) begin
      out_data_q <= {1'b0, held_stable_q, held_dev_q, held_mean_q, count_sat};
      out_user_q <= {updated_q, sampled_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW_DEPTH))
    else $error("filled-slot count exceeds window depth");

  a_cnt_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) == (sum_q == '0))
    else $error("running count and sum disagree on an empty window");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |->
      held_stable_q == STABLE_W'(held_mean_q) + STABLE_W'({held_dev_q, 1'b0}))
    else $error("held stable latency out of step with mean and deviation");

  a_upd_smp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_user_q[1] |-> out_user_q[0])
    else $error("update reported on a tick that took no sample");

endmodule

`default_nettype wire
